// File: src/assert_macros.svh
// Shared assertion macros for the merge block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bwm_pkg.sv
package bwm_pkg;

    // Fixed field widths
    localparam int FIELD_W     = 32;
    localparam int KEY_BITS_W  = 4;
    localparam int LOG_KEYS_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int NUM_STAGES  = 2 ** LOG_KEYS_W;
    // (b+1) << (lk+1) reaches 256
    localparam int SHIFT_W     = 9;
    // (b+1) << lk reaches 128
    localparam int HALF_W      = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOG_KEYS = 2'd1;

    // Register reset values
    localparam logic [KEY_BITS_W-1:0] KEY_BITS_RST = 4'd7;
    localparam logic [LOG_KEYS_W-1:0] LOG_KEYS_RST = 2'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] first_word;
        logic [FIELD_W-1:0] second_word;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] merged_word;
        logic [FIELD_W-1:0] lower_half;
        logic [FIELD_W-1:0] upper_half;
        logic               config_error;
    } out_t;

    typedef struct packed {
        logic [KEY_BITS_W-1:0] key_bits;
        logic [LOG_KEYS_W-1:0] log_keys;
        logic [HALF_W-1:0]     half;
        logic                  config_error;
    } cfg_ctrl_t;

endpackage

// File: src/bwm_cfg.sv
module bwm_cfg
    import bwm_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_ctrl_t              ctrl,
    output logic [WORD_BITS-1:0]   test_mask,
    output logic [WORD_BITS-1:0]   sel_mask [NUM_STAGES],
    output logic [WORD_BITS-1:0]   low_mask
);

    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

    logic [KEY_BITS_W-1:0] key_bits_reg, key_bits_next;
    logic [LOG_KEYS_W-1:0] log_keys_reg, log_keys_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic                  error_reg, error_next;
    logic [WORD_BITS-1:0]  test_mask_reg, test_mask_next;
    logic [WORD_BITS-1:0]  low_mask_reg, low_mask_next;
    logic [WORD_BITS-1:0]  sel_mask_reg [NUM_STAGES];
    logic [WORD_BITS-1:0]  sel_mask_next [NUM_STAGES];
    logic [WORD_BITS-1:0]  pair_mask [NUM_STAGES+1];
    logic [4:0]            field_w;
    logic [SHIFT_W-1:0]    total_w;
    logic [SHIFT_W-1:0]    mask_shift;
    logic [HALF_W-1:0]     pair_dist;

    assign cfg_ready = 1'b1;

    // Select the register values for the next cycle
    always_comb begin
        key_bits_next = key_bits_reg;
        log_keys_next = log_keys_reg;
        if (!aresetn) begin
            key_bits_next = KEY_BITS_RST;
            log_keys_next = LOG_KEYS_RST;
        end else if (cfg_valid && cfg_index == CFG_KEY_BITS) begin
            key_bits_next = cfg_data[KEY_BITS_W-1:0];
        end else if (cfg_valid && cfg_index == CFG_LOG_KEYS) begin
            log_keys_next = cfg_data[LOG_KEYS_W-1:0];
        end
    end

    // Derive field geometry and the per-stage masks from the next settings
    always_comb begin
        field_w    = {1'b0, key_bits_next} + 5'd1;
        total_w    = SHIFT_W'(field_w) << ({1'b0, log_keys_next} + 3'd1);
        error_next = (key_bits_next == '0) || (total_w > SHIFT_W'(WORD_BITS));
        half_next  = HALF_W'(SHIFT_W'(field_w) << log_keys_next);

        // Test bits of all 2k fields
        test_mask_next = ONE << key_bits_next;
        mask_shift = SHIFT_W'(field_w);
        for (int t = 0; t < NUM_STAGES; t++) begin
            if (LOG_KEYS_W'(t) <= log_keys_next) begin
                test_mask_next = test_mask_next | (test_mask_next << mask_shift);
            end
            mask_shift = mask_shift << 1;
        end

        // Test bits of the lower field of each compare pair
        pair_mask[0] = test_mask_next;
        pair_dist = half_next;
        for (int t = 0; t < NUM_STAGES; t++) begin
            if (LOG_KEYS_W'(t) <= log_keys_next) begin
                pair_mask[t+1] = pair_mask[t] ^ (pair_mask[t] << pair_dist);
            end else begin
                pair_mask[t+1] = pair_mask[t];
            end
            pair_dist = pair_dist >> 1;
        end

        // Spread each test bit over its key
        for (int t = 0; t < NUM_STAGES; t++) begin
            sel_mask_next[t] = pair_mask[t+1] - (pair_mask[t+1] >> key_bits_next);
        end

        low_mask_next = (ONE << half_next) - ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bits_reg <= KEY_BITS_RST;
            log_keys_reg <= LOG_KEYS_RST;
        end else begin
            key_bits_reg <= key_bits_next;
            log_keys_reg <= log_keys_next;
        end
    end

    // Hold derived values; the next values already follow reset
    always_ff @(posedge aclk) begin
        half_reg      <= half_next;
        error_reg     <= error_next;
        test_mask_reg <= test_mask_next;
        low_mask_reg  <= low_mask_next;
        sel_mask_reg  <= sel_mask_next;
    end

    assign ctrl.key_bits     = key_bits_reg;
    assign ctrl.log_keys     = log_keys_reg;
    assign ctrl.half         = half_reg;
    assign ctrl.config_error = error_reg;
    assign test_mask         = test_mask_reg;
    assign low_mask          = low_mask_reg;
    assign sel_mask          = sel_mask_reg;

endmodule

// File: src/bwm_merge.sv
module bwm_merge
    import bwm_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  in_t                  in_data,
    input  cfg_ctrl_t            ctrl,
    input  logic [WORD_BITS-1:0] test_mask,
    input  logic [WORD_BITS-1:0] sel_mask [NUM_STAGES],
    input  logic [WORD_BITS-1:0] low_mask,
    output out_t                 result
);

    logic [WORD_BITS-1:0] x, y, z, a, bb, n;
    logic [HALF_W-1:0]    shift_amt;
    logic [63:0]          z_wide, low_wide, up_wide;

    always_comb begin
        x = WORD_BITS'(in_data.first_word);
        y = WORD_BITS'(in_data.second_word);

        // Reverse the field order of the second word
        shift_amt = ctrl.half;
        for (int t = 0; t < NUM_STAGES; t++) begin
            if (LOG_KEYS_W'(t) <= ctrl.log_keys) begin
                y = ((y & sel_mask[t]) << shift_amt) | ((y & ~sel_mask[t]) >> shift_amt);
            end
            shift_amt = shift_amt >> 1;
        end
        z = x | y;

        // Bitonic compare-exchange, distance halving each stage
        a         = '0;
        bb        = '0;
        n         = '0;
        shift_amt = ctrl.half;
        for (int t = 0; t < NUM_STAGES; t++) begin
            if (LOG_KEYS_W'(t) <= ctrl.log_keys) begin
                a  = (z & sel_mask[t]) << shift_amt;
                bb = z & ~sel_mask[t];
                n  = ((bb | test_mask) - a) & test_mask;
                n  = n - (n >> ctrl.key_bits);
                z  = (bb & n) | (a & ~n) | ((a & n) >> shift_amt) |
                     ((bb & ~n) >> shift_amt);
            end
            shift_amt = shift_amt >> 1;
        end

        z_wide   = 64'(z);
        low_wide = 64'(z & low_mask);
        up_wide  = 64'(z >> ctrl.half);

        // Drop all word fields on an unusable configuration
        if (ctrl.config_error) begin
            result.merged_word  = '0;
            result.lower_half   = '0;
            result.upper_half   = '0;
            result.config_error = 1'b1;
        end else begin
            result.merged_word  = z_wide[FIELD_W-1:0];
            result.lower_half   = low_wide[FIELD_W-1:0];
            result.upper_half   = up_wide[FIELD_W-1:0];
            result.config_error = 1'b0;
        end
    end

endmodule

// File: src/packed_word_bitonic_merge.sv
// Merge of two packed words of k ascending keys into one word of 2k keys.
//
// Input channel s_valid/s_ready/s_data carries first_word and second_word;
// each holds k keys of key_bits bits in fields of key_bits+1 bits with a zero
// test bit on top, smallest key in the lowest field. The result channel
// m_valid/m_ready/m_data returns the merged word, its lower and upper halves
// and config_error. A configuration that does not fit the word (2k fields
// wider than WORD_BITS, or a zero key width) gives config_error and zeros.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// key_bits (index 0) and log_keys_per_word (index 1); cfg_ready is always
// high. Write it only while no word is in flight.
//
// m_valid rises once an accepted word has passed the input register, then
// the reversal and compare-exchange stages in one combinational pass into
// the output register. One word is accepted per cycle while the receiver
// keeps up and s_ready stays high. When the receiver
// stalls, the output register holds its word and the input register takes
// one more; s_ready drops once both are full. Reset empties both registers
// and sets key_bits to 7 and log_keys_per_word to 1.
module packed_word_bitonic_merge
    import bwm_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_ctrl_t            ctrl;
    logic [WORD_BITS-1:0] test_mask;
    logic [WORD_BITS-1:0] sel_mask [NUM_STAGES];
    logic [WORD_BITS-1:0] low_mask;

    logic in_valid_reg;
    in_t  in_data_reg;
    logic m_valid_reg;
    out_t out_data_reg;
    out_t result;
    logic out_free;

    bwm_cfg #(
        .WORD_BITS(WORD_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .test_mask (test_mask),
        .sel_mask  (sel_mask),
        .low_mask  (low_mask)
    );

    bwm_merge #(
        .WORD_BITS(WORD_BITS)
    ) u_merge (
        .in_data   (in_data_reg),
        .ctrl      (ctrl),
        .test_mask (test_mask),
        .sel_mask  (sel_mask),
        .low_mask  (low_mask),
        .result    (result)
    );

    // Advance when the output register is empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture the word on accept; hold the result while stalled
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (out_free && in_valid_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: src/bwm_checker.sv
`include "assert_macros.svh"

module bwm_checker
    import bwm_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // A stalled result keeps its word
    `ASSERT_CLK(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // An accepted word moves through the input register into the output register or finds the output busy
    `ASSERT_CLK(a_latency, aclk, aresetn, s_valid && s_ready |-> ##2 m_valid, "accepted word did not reach the output")

    // A flagged configuration delivers zero words
    `ASSERT_CLK(a_err_zero, aclk, aresetn, m_valid && m_data.config_error |-> m_data.merged_word == '0 && m_data.lower_half == '0 && m_data.upper_half == '0, "error result not zero")

    // The lower half is a part of the merged word
    `ASSERT_CLK(a_lower_sub, aclk, aresetn, m_valid && !m_data.config_error |-> (m_data.lower_half | m_data.merged_word) == m_data.merged_word, "lower half not within merged word")

    // Reset empties the output
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind packed_word_bitonic_merge bwm_checker u_bwm_checker (.*);

// File: dv/tb_packed_word_bitonic_merge.sv
module tb_packed_word_bitonic_merge;
    import bwm_pkg::*;

    localparam int WORD_BITS      = 32;
    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_CYCLES   = 48;
    localparam int ITEMS_PER_SET  = 54;
    localparam int SETS_PER_PHASE = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    // Index with no register behind it; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_t                    s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_t                   m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Local copy of the register file
    logic [KEY_BITS_W-1:0]  key_bits_q;
    logic [LOG_KEYS_W-1:0]  log_keys_q;

    out_t pending_merges[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_request;
    int   stall_left;
    int   words_sent;
    int   settings_used;
    int   errors;

    packed_word_bitonic_merge #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Spread each set test bit into a run of ones over the key below it
    function automatic logic [FIELD_W-1:0] spread_test(input logic [FIELD_W-1:0] a,
                                                       input int unsigned b);
        return a - (a >> b);
    endfunction

    // Merge of two packed runs under the given register values
    function automatic out_t predict_merge(input in_t d,
                                           input logic [KEY_BITS_W-1:0] kb,
                                           input logic [LOG_KEYS_W-1:0] lk);
        logic [FIELD_W-1:0] tmask [0:4];
        logic [FIELD_W-1:0] y, z, m, a, bb, n;
        int unsigned        b, lkv, s, half, t;
        out_t               r;
        b   = kb;
        lkv = lk;
        r   = '0;
        // Zero key width or 2k fields wider than the word
        if (b == 0 || ((b + 1) << (lkv + 1)) > WORD_BITS) begin
            r.config_error = 1'b1;
            return r;
        end
        // Test bits of all 2k fields
        tmask[0] = 32'd1 << b;
        s = b + 1;
        for (t = 0; t <= lkv; t++) begin
            tmask[0] = tmask[0] | (tmask[0] << s);
            s = s << 1;
        end
        // Lower field of each compare pair, one selector per stage
        half = (b + 1) << lkv;
        s = half;
        for (t = 0; t <= lkv; t++) begin
            tmask[t + 1] = tmask[t] ^ (tmask[t] << s);
            s = s >> 1;
        end
        // Reverse the field order of the second word
        y = d.second_word;
        s = half;
        for (t = 0; t <= lkv; t++) begin
            m = spread_test(tmask[t + 1], b);
            y = ((y & m) << s) | ((y - (y & m)) >> s);
            s = s >> 1;
        end
        z = d.first_word | y;
        // Compare-exchange at distances k, k/2, ..., 1 fields
        s = half;
        for (t = 0; t <= lkv; t++) begin
            m  = spread_test(tmask[t + 1], b);
            a  = (z & m) << s;
            bb = z - (z & m);
            n  = ((bb | tmask[0]) - a) & tmask[0];
            n  = spread_test(n, b);
            z  = (bb & n) | (a - (a & n)) | ((a & n) >> s) | ((bb - (bb & n)) >> s);
            s  = s >> 1;
        end
        r.merged_word = z;
        r.lower_half  = z & ((32'd1 << half) - 32'd1);
        r.upper_half  = z >> half;
        return r;
    endfunction

    // Random word of k ascending b-bit keys, test bits clear
    function automatic logic [FIELD_W-1:0] sorted_word(input int unsigned b,
                                                       input int unsigned k);
        int unsigned        keys [8];
        int unsigned        span, tmp;
        int                 i, j;
        logic [FIELD_W-1:0] w;
        span = (1 << b) - 1;
        // Narrow the range now and then to force equal keys
        if ($urandom_range(3) == 0 && span > 3)
            span = 3;
        for (i = 0; i < k; i++)
            keys[i] = $urandom_range(span);
        for (i = 1; i < k; i++) begin
            tmp = keys[i];
            j = i - 1;
            while (j >= 0 && keys[j] > tmp) begin
                keys[j + 1] = keys[j];
                j--;
            end
            keys[j + 1] = tmp;
        end
        w = '0;
        for (i = 0; i < k; i++)
            w = w | (keys[i] << (i * (b + 1)));
        return w;
    endfunction

    // Offer one word pair, with random idle cycles ahead of it
    task automatic send_words(input logic [FIELD_W-1:0] fw, input logic [FIELD_W-1:0] sw);
        in_t  item;
        out_t want;
        item.first_word  = fw;
        item.second_word = sw;
        want = predict_merge(item, key_bits_q, log_keys_q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_merges.push_back(want);
        words_sent++;
    endtask

    // Drop valid and wait until every merge has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_merges.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_BITS)
            key_bits_q = val;
        else if (idx == CFG_LOG_KEYS)
            log_keys_q = val[LOG_KEYS_W-1:0];
        @(posedge aclk);
    endtask

    // Load both registers once the block is idle
    task automatic set_config(input logic [KEY_BITS_W-1:0] b,
                              input logic [LOG_KEYS_W-1:0] lk);
        logic [CFG_DATA_W-LOG_KEYS_W-1:0] pad;
        wait_drained();
        // Unused upper data bits must not matter
        pad = (CFG_DATA_W-LOG_KEYS_W)'($urandom_range(3));
        write_reg(CFG_KEY_BITS, b);
        write_reg(CFG_LOG_KEYS, {pad, lk});
        settings_used++;
    endtask

    // Reset values: 7-bit keys, two keys per word, four 8-bit fields
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_words(32'h0000_0000, 32'h0000_0000);
        send_words(32'h0000_7F7F, 32'h0000_7F7F);
        send_words(32'h0000_7F00, 32'h0000_7F00);
        // first run entirely below the second, then above
        send_words(32'h0000_0201, 32'h0000_0403);
        send_words(32'h0000_0403, 32'h0000_0201);
        send_words(32'h0000_0401, 32'h0000_0302);
        send_words(32'h0000_0505, 32'h0000_0505);
        // malformed: all ones, set test bits, unsorted runs
        send_words(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_words(32'h8080_8080, 32'h0000_0000);
        send_words(32'h0000_0209, 32'h0000_0107);
        wait_drained();
    endtask

    // Widest and narrowest key widths and key counts that still fit
    task automatic test_key_extremes();
        set_config(4'd1, 2'd3);
        send_words(32'h0000_5555, 32'h0000_0000);
        send_words(32'h0000_5500, 32'h0000_5540);
        set_config(4'd15, 2'd0);
        send_words(32'h0000_7FFF, 32'h0000_0000);
        send_words(32'h0000_1234, 32'h0000_1233);
        // bits above the two fields are left in the inputs
        set_config(4'd3, 2'd0);
        send_words(32'hABCD_EF05, 32'h1234_5603);
        set_config(4'd3, 2'd2);
        send_words(32'h0000_7210, 32'h0000_6533);
        wait_drained();
    endtask

    // Zero key width, oversized settings and a write to an unused index
    task automatic test_bad_config();
        set_config(4'd0, 2'd1);
        send_words(32'h0000_0201, 32'h0000_0403);
        set_config(4'd15, 2'd1);
        send_words($urandom, $urandom);
        set_config(4'd8, 2'd1);
        send_words(32'h0000_0201, 32'h0000_0403);
        set_config(4'd3, 2'd3);
        send_words($urandom, $urandom);
        set_config(4'd7, 2'd1);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(15)));
        send_words(32'h0000_0401, 32'h0000_0302);
        wait_drained();
    endtask

    // Hold the output long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int i;
        set_config(4'd7, 2'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge aclk);
        stall_request = STALL_CYCLES;
        @(posedge aclk);
        for (i = 0; i < 30; i++)
            send_words(sorted_word(7, 2), sorted_word(7, 2));
        wait_drained();
    endtask

    // Mostly well-formed runs, some noise and some runs with one bit flipped
    task automatic test_random(input int send_pct, input int recv_pct);
        int unsigned        b, lk, k;
        int                 set_n, item_n, mix;
        logic [FIELD_W-1:0] fw, sw;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (set_n = 0; set_n < SETS_PER_PHASE; set_n++) begin
            case (set_n)
                0: begin b = 1;  lk = 0; end
                1: begin b = 15; lk = 0; end
                2: begin b = 7;  lk = 1; end
                3: begin b = 3;  lk = 2; end
                4: begin b = 1;  lk = 3; end
                5: begin b = 0;  lk = 2; end
                6: begin b = 15; lk = 3; end
                7: begin b = 8;  lk = 1; end
                default: begin
                    lk = $urandom_range(3);
                    b  = $urandom_range((16 >> lk) - 1, 1);
                end
            endcase
            set_config(b[KEY_BITS_W-1:0], lk[LOG_KEYS_W-1:0]);
            k = 1 << lk;
            for (item_n = 0; item_n < ITEMS_PER_SET; item_n++) begin
                mix = $urandom_range(99);
                if (mix < 10 || b == 0 || ((b + 1) << (lk + 1)) > WORD_BITS) begin
                    fw = $urandom;
                    sw = $urandom;
                end else begin
                    fw = sorted_word(b, k);
                    sw = sorted_word(b, k);
                    if (mix < 20) begin
                        if ($urandom_range(1) == 1)
                            fw = fw ^ (32'd1 << $urandom_range(31));
                        else
                            sw = sw ^ (32'd1 << $urandom_range(31));
                    end
                end
                send_words(fw, sw);
            end
        end
        wait_drained();
    endtask

    // Drive ready, with a long hold-off when one is requested
    always @(posedge aclk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result word with the oldest pending merge
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_merges.size() == 0) begin
                $error("result word with no merge pending: %h", m_data);
                errors++;
            end else begin
                want = pending_merges.pop_front();
                if (m_data.merged_word !== want.merged_word) begin
                    $error("merged_word: expected %h, actual %h",
                           want.merged_word, m_data.merged_word);
                    errors++;
                end
                if (m_data.lower_half !== want.lower_half) begin
                    $error("lower_half: expected %h, actual %h",
                           want.lower_half, m_data.lower_half);
                    errors++;
                end
                if (m_data.upper_half !== want.upper_half) begin
                    $error("upper_half: expected %h, actual %h",
                           want.upper_half, m_data.upper_half);
                    errors++;
                end
                if (m_data.config_error !== want.config_error) begin
                    $error("config_error: expected %b, actual %b",
                           want.config_error, m_data.config_error);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("tb_packed_word_bitonic_merge NOT OK");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KEY_BITS;
        cfg_data      = '0;
        key_bits_q    = KEY_BITS_RST;
        log_keys_q    = LOG_KEYS_RST;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 0;
        stall_left    = 0;
        words_sent    = 0;
        settings_used = 0;
        errors        = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_key_extremes();
        test_bad_config();
        test_backpressure();
        test_random(38, 59);
        test_random(59, 38);
        test_random(0, 0);

        wait_drained();
        if (pending_merges.size() != 0) begin
            $error("%0d merges never came back", pending_merges.size());
            errors++;
        end
        $display("Merged %0d word pairs over %0d register settings, idle gaps on both sides,",
                 words_sent, settings_used);
        $display("one %0d-cycle output stall; %0d mismatches.", STALL_CYCLES, errors);
        if (errors == 0)
            $display("tb_packed_word_bitonic_merge OK");
        else
            $display("tb_packed_word_bitonic_merge NOT OK");
        $finish;
    end

endmodule
